[src/lavg_pkg.sv]
// Shared types and constants for the LED animation block with supply-voltage guard.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lavg_pkg;

    localparam int NUM_LEDS    = 42;
    localparam int IDX_W       = 6;
    localparam int PHASE_W     = 9;
    localparam int CNT_W       = 5;
    localparam int SAMPLE_W    = 12;
    localparam int CNT_CFG_W   = 4;
    localparam int COLOR_W     = 24;

    localparam logic [PHASE_W-1:0] STARTUP_END = PHASE_W'(256);
    localparam logic [PHASE_W-1:0] RAMP_UP_END = PHASE_W'(64);
    localparam logic [PHASE_W-1:0] RAMP_END    = PHASE_W'(319);
    localparam logic [CNT_W-1:0]   CNT_MAX     = CNT_W'(31);
    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(NUM_LEDS - 1);

    localparam logic [SAMPLE_W-1:0]  RST_LOW_THR = SAMPLE_W'(650);
    localparam logic [CNT_CFG_W-1:0] RST_OFF_CNT = CNT_CFG_W'(5);
    localparam logic [CNT_CFG_W-1:0] RST_ON_CNT  = CNT_CFG_W'(10);
    localparam logic [CNT_CFG_W-1:0] RST_RETRY   = CNT_CFG_W'(4);

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        CFG_LOW_THR = 2'd0,
        CFG_OFF_CNT = 2'd1,
        CFG_ON_CNT  = 2'd2,
        CFG_RETRY   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FR_STATUS = 2'd0,
        FR_BLACK  = 2'd1,
        FR_SWEEP  = 2'd2,
        FR_GREEN  = 2'd3
    } t_frame;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] voltage_sample;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] pixel_color;
        logic               power_enable;
        logic               low_voltage;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  low_thr;
        logic [CNT_CFG_W-1:0] off_cnt;
        logic [CNT_CFG_W-1:0] on_cnt;
        logic [CNT_CFG_W-1:0] retry;
    } t_cfg;

    // Work handed from the guard to the emitter for one accepted item
    typedef struct packed {
        logic               start;
        t_frame             frame;
        logic [PHASE_W-1:0] phase;
        logic               pwr;
        logic               lov;
    } t_job;

    typedef struct packed {
        logic power_on;
        logic under_voltage;
    } t_guard_st;

endpackage

[src/lavg_ctrl.sv]
// Voltage guard and animation state: updates on each accepted item and
// describes the run of results it causes. Depends on lavg_pkg.
`timescale 1ns / 1ps

module lavg_ctrl import lavg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_job      o_job,
    output t_guard_st o_st
);

    logic               r_mode;
    logic [PHASE_W-1:0] r_phase;
    logic               r_power_on;
    logic               r_under_v;
    logic [CNT_W-1:0]   r_cnt;

    logic               n_mode;
    logic [PHASE_W-1:0] n_phase;
    logic               n_power_on;
    logic               n_under_v;
    logic [CNT_W-1:0]   n_cnt;

    logic [CNT_W-1:0]   cnt_inc;
    logic [PHASE_W-1:0] phase_inc;

    assign cnt_inc   = (r_cnt < CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;
    assign phase_inc = r_phase + PHASE_W'(1);

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_power_on = r_power_on;
        n_under_v  = r_under_v;
        n_cnt      = r_cnt;
        o_job      = '{start: 1'b0, frame: FR_STATUS, phase: '0, pwr: 1'b0, lov: 1'b0};

        if (i_item.req_type == REQ_SAMPLE) begin
            if (i_item.voltage_sample < i_cfg.low_thr) begin
                n_under_v = 1'b1;
                n_mode    = 1'b0;
                n_phase   = '0;
                priority if (r_power_on && (cnt_inc > CNT_W'(i_cfg.off_cnt))) begin
                    n_power_on = 1'b0;
                    n_cnt      = '0;
                end else if (!r_power_on && (cnt_inc > CNT_W'(i_cfg.on_cnt))) begin
                    n_power_on = 1'b1;
                    n_cnt      = CNT_W'(i_cfg.retry);
                end else begin
                    n_cnt = cnt_inc;
                end
            end else begin
                n_under_v  = 1'b0;
                n_power_on = 1'b1;
                n_cnt      = '0;
            end
            o_job.start = 1'b1;
            o_job.frame = FR_STATUS;
            o_job.pwr   = n_power_on;
            o_job.lov   = n_under_v;
        end else if (r_power_on) begin
            priority if (r_under_v) begin
                o_job.start = 1'b1;
                o_job.frame = FR_BLACK;
            end else if (!r_mode) begin
                // Reaching the end of the sweep switches to running and shows nothing
                if (phase_inc >= STARTUP_END) begin
                    n_phase = '0;
                    n_mode  = 1'b1;
                end else begin
                    n_phase     = phase_inc;
                    o_job.start = 1'b1;
                    o_job.frame = FR_SWEEP;
                    o_job.phase = phase_inc;
                end
            end else begin
                n_phase     = (phase_inc >= RAMP_END) ? '0 : phase_inc;
                o_job.start = 1'b1;
                o_job.frame = FR_GREEN;
                o_job.phase = n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_phase    <= '0;
            r_power_on <= 1'b0;
            r_under_v  <= 1'b0;
            r_cnt      <= '0;
        end else if (i_take) begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_power_on <= n_power_on;
            r_under_v  <= n_under_v;
            r_cnt      <= n_cnt;
        end
    end

    assign o_st = '{power_on: r_power_on, under_voltage: r_under_v};

endmodule

[src/lavg_emit.sv]
// Result emitter: walks the LEDs of one frame (or sends one status result)
// into a registered output stage. Depends on lavg_pkg.
`timescale 1ns / 1ps

module lavg_emit import lavg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_job      i_job,
    input  logic      i_stall,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_data
);

    logic             r_busy;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             adv;
    logic             last_now;
    t_out_item        res;

    logic [PHASE_W-1:0] idx_ext;
    logic [PHASE_W-1:0] lag;
    logic [7:0]         trail;
    logic [7:0]         gv;
    logic [15:0]        gsq;
    logic [16:0]        gsum;
    logic [7:0]         gq;
    logic [7:0]         green;
    logic [COLOR_W-1:0] color;

    assign adv      = !r_out_valid || !i_stall;
    assign last_now = (r_job.frame == FR_STATUS) || (r_idx == LAST_IDX);
    assign o_ready  = !r_busy || (adv && last_now);

    // Sweep trail
    assign idx_ext = PHASE_W'(r_idx);
    assign lag     = r_job.phase - idx_ext;

    always_comb begin
        priority if (lag < PHASE_W'(3)) begin
            trail = 8'hFF >> lag[1:0];
        end else if (lag >= PHASE_W'(39)) begin
            trail = 8'd1;
        end else begin
            trail = 8'(PHASE_W'(40) - lag);
        end
    end

    // Breathing ramp with squared gamma; divide by 255 via reciprocal form
    always_comb begin
        if (r_job.phase < RAMP_UP_END) begin
            gv = {r_job.phase[5:0], 2'b11};
        end else if (r_job.phase < RAMP_END) begin
            gv = 8'(RAMP_END - r_job.phase);
        end else begin
            gv = 8'd0;
        end
    end

    assign gsq   = 16'(gv) * 16'(gv);
    assign gsum  = 17'(gsq) + 17'(gsq >> 8) + 17'd1;
    assign gq    = gsum[15:8];
    assign green = (gq == 8'd0) ? 8'd1 : gq;

    always_comb begin
        unique case (r_job.frame)
            FR_SWEEP: begin
                if (idx_ext == r_job.phase) begin
                    color = COLOR_WHITE;
                end else if (idx_ext < r_job.phase) begin
                    color = {trail, trail, trail};
                end else begin
                    color = '0;
                end
            end
            FR_GREEN: color = {8'd0, green, 8'd0};
            default:  color = '0;
        endcase
    end

    always_comb begin
        if (r_job.frame == FR_STATUS) begin
            res = '{result_kind: KIND_STATUS, pixel_index: '0, pixel_color: '0,
                    power_enable: r_job.pwr, low_voltage: r_job.lov, last_of_run: 1'b1};
        end else begin
            res = '{result_kind: KIND_PIXEL, pixel_index: r_idx, pixel_color: color,
                    power_enable: 1'b0, low_voltage: 1'b0, last_of_run: last_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            if (r_busy && adv) begin
                if (last_now) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            // A new run takes over as the old one hands off its last result
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
        if (r_busy && adv) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[src/led_animation_with_voltage_guard.sv]
// Top level: LED animation with supply-voltage guard, configuration registers
// and channel handshakes. Depends on lavg_pkg, lavg_ctrl and lavg_emit.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------
//  request  | in        | i_valid / o_stall        | i_data  (t_in_item)
//  result   | out       | o_valid / i_stall        | o_data  (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A voltage sample gives one status result; a frame tick with power on gives
// NUM_LEDS pixel results (none at the end of the startup sweep), one per cycle
// from the emitter counter while not stalled. The next request is taken in the
// cycle the last result of the current run enters the output register.
// Output stall holds the output register and, once the emitter waits, the input.
// Synchronous active-low reset: power off, startup sweep, counters cleared.
`timescale 1ns / 1ps

module led_animation_with_voltage_guard import lavg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_idx             i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    t_cfg      r_cfg;
    t_job      job;
    t_guard_st guard_st;
    logic      emit_ready;
    logic      take;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !emit_ready;
    assign take        = i_valid && emit_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{low_thr: RST_LOW_THR, off_cnt: RST_OFF_CNT,
                       on_cnt: RST_ON_CNT, retry: RST_RETRY};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LOW_THR: r_cfg.low_thr <= i_cfg_data;
                CFG_OFF_CNT: r_cfg.off_cnt <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_ON_CNT:  r_cfg.on_cnt  <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_RETRY:   r_cfg.retry   <= i_cfg_data[CNT_CFG_W-1:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    lavg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_data),
        .i_cfg   (r_cfg),
        .o_job   (job),
        .o_st    (guard_st)
    );

    lavg_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && job.start),
        .i_job   (job),
        .i_stall (i_stall),
        .o_ready (emit_ready),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.result_kind == KIND_STATUS |-> o_data.last_of_run)
        else $error("status result not marked last");

    a_pixel_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.result_kind == KIND_PIXEL && o_data.last_of_run
        |-> o_data.pixel_index == LAST_IDX)
        else $error("pixel run ended at wrong index");

    a_power_by_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(guard_st.power_on) |-> $past(take && i_data.req_type == REQ_SAMPLE))
        else $error("power enabled without a voltage sample");

    a_low_v_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(guard_st.under_voltage) |-> $past(take && i_data.req_type == REQ_SAMPLE))
        else $error("low voltage set without a voltage sample");

endmodule
